/* hw/rtl/ftkps_pkg.sv */
package ftkps_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int COORD_BITS = 24;
  localparam int COUNT_BITS = 16;

  localparam int INTENS_BITS   = 16;
  localparam int DIST_BITS     = 23;
  localparam int HITS_BITS     = 5;
  localparam int RANK_BITS     = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int HITS_RESET    = 4;

  // squared-distance arithmetic
  localparam int RANGE_BITS = 23;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * RANGE_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;

  localparam int FILL_BITS     = $clog2(MAX_KEEP + 1);
  localparam int KEEP_IDX_BITS = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // pipeline depth from request accept to list insertion
  localparam int STAGES = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_INTENSITY = 3'd0,
    CFG_MIN_DISTANCE  = 3'd1,
    CFG_ORIGIN_X      = 3'd2,
    CFG_ORIGIN_Y      = 3'd3,
    CFG_ORIGIN_Z      = 3'd4,
    CFG_MAX_HITS      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic load;    // request accepted into the first stage
    logic insert;  // last stage holds a point to sort in
    logic shift;   // result taken, move the list up by one
    logic clear;   // last result taken, start a new batch
  } cmd_t;

  typedef struct packed {
    logic emit_last;  // current result is the final one of the batch
  } status_t;

endpackage

/* hw/rtl/filtered_top_k_point_selector.sv */
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------------------------
// in        | in        | in_valid / in_stall | pos_*, intensity, offset_*, batch_end
// out       | out       | out_valid/out_stall | world_*, strength, rank, flags, batch counts
// cfg       | in        | cfg_we              | cfg_index, cfg_data
//
// points enter one per cycle while in_stall is low into a four-stage filter pipeline
// (saturated add, axis distance, squares, near test); the sorted cell chain takes one
// point per cycle; a request with batch_end closes the input until the batch has drained,
// then one result per cycle when not stalled, min(fill, limit) results or one empty result
// synchronous reset clears the counts, fill and pipeline valids and resets the config registers
// out_stall only holds the current result; it never reaches the input side before batch end
module filtered_top_k_point_selector
  import ftkps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // point requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic [INTENS_BITS-1:0]       intensity,
  input  logic signed [COORD_BITS-1:0] offset_x,
  input  logic signed [COORD_BITS-1:0] offset_y,
  input  logic signed [COORD_BITS-1:0] offset_z,
  input  logic                         batch_end,
  // selected points
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] world_x,
  output logic signed [COORD_BITS-1:0] world_y,
  output logic signed [COORD_BITS-1:0] world_z,
  output logic [INTENS_BITS-1:0]       strength,
  output logic [RANK_BITS-1:0]         rank,
  output logic                         final_result,
  output logic                         none_kept,
  output logic [COUNT_BITS-1:0]        received_count,
  output logic [COUNT_BITS-1:0]        too_close_count,
  output logic [COUNT_BITS-1:0]        kept_count,
  // register writes
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencing: pipeline valids, batch end tracking, emit phase
  ftkps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .batch_end (batch_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // filters, distance arithmetic, sorted cells and batch counters
  ftkps_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .intensity       (intensity),
    .offset_x        (offset_x),
    .offset_y        (offset_y),
    .offset_z        (offset_z),
    .world_x         (world_x),
    .world_y         (world_y),
    .world_z         (world_z),
    .strength        (strength),
    .rank            (rank),
    .final_result    (final_result),
    .none_kept       (none_kept),
    .received_count  (received_count),
    .too_close_count (too_close_count),
    .kept_count      (kept_count)
  );

  // no new point may enter while results are being drained
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("point accepted during emit");

  // a batch end request closes the input on the next cycle
  a_end_closes_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && batch_end) |=> in_stall)
    else $error("input open after batch end");

  // an empty batch gives a single final result at rank zero
  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_kept) |-> (final_result && rank == '0))
    else $error("empty result not final");

  // taking the final result ends the emit phase
  a_final_ends_emit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && final_result) |=> !out_valid)
    else $error("results after final");

endmodule

/* hw/rtl/ftkps_ctrl.sv */
module ftkps_ctrl
  import ftkps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    batch_end,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [STAGES-1:0] vld, endf;
  logic              accept, out_take;

  assign in_stall  = (state == ST_EMIT) || ((vld & endf) != '0);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == ST_EMIT);
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    cmd.load   = accept;
    cmd.insert = vld[STAGES-1];
    cmd.shift  = out_take && !status.emit_last;
    cmd.clear  = out_take && status.emit_last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (vld[STAGES-1] && endf[STAGES-1]) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_take && status.emit_last) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      vld   <= '0;
      endf  <= '0;
    end else begin
      state <= state_next;
      vld   <= {vld[STAGES-2:0], accept};
      endf  <= {endf[STAGES-2:0], accept && batch_end};
    end
  end

endmodule

/* hw/rtl/ftkps_dp.sv */
module ftkps_dp
  import ftkps_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  cmd_t                            cmd,
  output status_t                         status,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0]    pos_x,
  input  logic signed [COORD_BITS-1:0]    pos_y,
  input  logic signed [COORD_BITS-1:0]    pos_z,
  input  logic [INTENS_BITS-1:0]          intensity,
  input  logic signed [COORD_BITS-1:0]    offset_x,
  input  logic signed [COORD_BITS-1:0]    offset_y,
  input  logic signed [COORD_BITS-1:0]    offset_z,
  output logic signed [COORD_BITS-1:0]    world_x,
  output logic signed [COORD_BITS-1:0]    world_y,
  output logic signed [COORD_BITS-1:0]    world_z,
  output logic [INTENS_BITS-1:0]          strength,
  output logic [RANK_BITS-1:0]            rank,
  output logic                            final_result,
  output logic                            none_kept,
  output logic [COUNT_BITS-1:0]           received_count,
  output logic [COUNT_BITS-1:0]           too_close_count,
  output logic [COUNT_BITS-1:0]           kept_count
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [INTENS_BITS-1:0]       s;
  } point_t;

  function automatic logic signed [COORD_BITS-1:0] sat_add(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] sum;
    sum = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    if (sum[COORD_BITS] == sum[COORD_BITS-1]) return sum[COORD_BITS-1:0];
    else if (sum[COORD_BITS]) return {1'b1, {(COORD_BITS-1){1'b0}}};
    else return {1'b0, {(COORD_BITS-1){1'b1}}};
  endfunction

  function automatic logic [DIFF_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // configuration
  logic [INTENS_BITS-1:0]       min_intensity;
  logic [DIST_BITS-1:0]         min_distance;
  logic signed [COORD_BITS-1:0] origin_x, origin_y, origin_z;
  logic [HITS_BITS-1:0]         max_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_intensity <= '0;
      min_distance  <= '0;
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      max_hits      <= HITS_BITS'(HITS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_INTENSITY: min_intensity <= cfg_data[INTENS_BITS-1:0];
        CFG_MIN_DISTANCE:  min_distance  <= cfg_data[DIST_BITS-1:0];
        CFG_ORIGIN_X:      origin_x      <= cfg_data[COORD_BITS-1:0];
        CFG_ORIGIN_Y:      origin_y      <= cfg_data[COORD_BITS-1:0];
        CFG_ORIGIN_Z:      origin_z      <= cfg_data[COORD_BITS-1:0];
        CFG_MAX_HITS:      max_hits      <= cfg_data[HITS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: saturated world position, intensity filter
  point_t s1_pt;
  logic   s1_ipass;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1_pt.x  <= sat_add(pos_x, offset_x);
      s1_pt.y  <= sat_add(pos_y, offset_y);
      s1_pt.z  <= sat_add(pos_z, offset_z);
      s1_pt.s  <= intensity;
      s1_ipass <= (intensity >= min_intensity);
    end
  end

  // stage 2: distance per axis from the origin
  point_t                s2_pt;
  logic                  s2_ipass, s2_inr;
  logic [RANGE_BITS-1:0] s2_dx, s2_dy, s2_dz;
  logic [DIFF_BITS-1:0]  mag_x, mag_y, mag_z;

  assign mag_x = abs_diff(s1_pt.x, origin_x);
  assign mag_y = abs_diff(s1_pt.y, origin_y);
  assign mag_z = abs_diff(s1_pt.z, origin_z);

  always_ff @(posedge clk) begin
    s2_pt    <= s1_pt;
    s2_ipass <= s1_ipass;
    s2_inr   <= ((mag_x >> RANGE_BITS) == '0) && ((mag_y >> RANGE_BITS) == '0)
                && ((mag_z >> RANGE_BITS) == '0);
    s2_dx    <= RANGE_BITS'(mag_x);
    s2_dy    <= RANGE_BITS'(mag_y);
    s2_dz    <= RANGE_BITS'(mag_z);
  end

  // stage 3: squares
  point_t             s3_pt;
  logic               s3_ipass, s3_inr;
  logic [SQ_BITS-1:0] s3_sx, s3_sy, s3_sz, s3_md2;

  always_ff @(posedge clk) begin
    s3_pt    <= s2_pt;
    s3_ipass <= s2_ipass;
    s3_inr   <= s2_inr;
    s3_sx    <= SQ_BITS'(s2_dx) * SQ_BITS'(s2_dx);
    s3_sy    <= SQ_BITS'(s2_dy) * SQ_BITS'(s2_dy);
    s3_sz    <= SQ_BITS'(s2_dz) * SQ_BITS'(s2_dz);
    s3_md2   <= SQ_BITS'(min_distance) * SQ_BITS'(min_distance);
  end

  // stage 4: near test
  point_t              s4_pt;
  logic                s4_ipass, s4_near;
  logic [SUM_BITS-1:0] sq_sum;

  assign sq_sum = SUM_BITS'(s3_sx) + SUM_BITS'(s3_sy) + SUM_BITS'(s3_sz);

  always_ff @(posedge clk) begin
    s4_pt    <= s3_pt;
    s4_ipass <= s3_ipass;
    s4_near  <= s3_inr && (sq_sum < SUM_BITS'(s3_md2));
  end

  // sorted list cells, strongest in cell 0
  point_t                 cells [MAX_KEEP];
  point_t                 cells_next [MAX_KEEP];
  logic [MAX_KEEP-1:0]    ge;
  logic [FILL_BITS-1:0]   list_fill, fill_next, lim, cur_fill;
  logic [KEEP_IDX_BITS-1:0] emit_idx;
  logic [COUNT_BITS-1:0]  seen_count, near_count, pass_count;
  logic                   keep_it, ins_ok;

  always_comb begin
    if (max_hits == '0) lim = FILL_BITS'(1);
    else if (max_hits > MAX_KEEP) lim = FILL_BITS'(MAX_KEEP);
    else lim = FILL_BITS'(max_hits);
  end

  assign cur_fill = (list_fill < lim) ? list_fill : lim;
  assign keep_it  = s4_ipass && !s4_near;

  always_comb begin
    ins_ok = 1'b1;
    for (int i = 0; i < MAX_KEEP; i++) begin
      ge[i] = (FILL_BITS'(i) < cur_fill) && (cells[i].s >= s4_pt.s);
      if ((FILL_BITS'(i + 1) == lim) && ge[i]) ins_ok = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) cells_next[i] = cells[i];
    if (cmd.shift) begin
      for (int i = 0; i < MAX_KEEP - 1; i++) cells_next[i] = cells[i + 1];
    end else if (cmd.insert && keep_it) begin
      if (!ge[0]) cells_next[0] = s4_pt;
      for (int i = 1; i < MAX_KEEP; i++) begin
        if (!ge[i]) cells_next[i] = ge[i - 1] ? s4_pt : cells[i - 1];
      end
    end
  end

  always_comb begin
    fill_next = list_fill;
    if (cmd.clear) fill_next = '0;
    else if (cmd.insert && keep_it) begin
      fill_next = (ins_ok && (cur_fill < lim)) ? cur_fill + 1'b1 : cur_fill;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEEP; i++) cells[i] <= cells_next[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_fill  <= '0;
      emit_idx   <= '0;
      seen_count <= '0;
      near_count <= '0;
      pass_count <= '0;
    end else begin
      list_fill <= fill_next;
      if (cmd.clear) begin
        emit_idx   <= '0;
        seen_count <= '0;
        near_count <= '0;
        pass_count <= '0;
      end else begin
        if (cmd.shift) emit_idx <= emit_idx + 1'b1;
        if (cmd.load) seen_count <= count_up(seen_count);
        if (cmd.insert && s4_ipass) begin
          if (s4_near) near_count <= count_up(near_count);
          else pass_count <= count_up(pass_count);
        end
      end
    end
  end

  // result fields
  assign none_kept = (cur_fill == '0);
  assign status.emit_last = none_kept || (FILL_BITS'(emit_idx) + 1'b1 == cur_fill);
  assign final_result = status.emit_last;

  assign world_x  = none_kept ? '0 : cells[0].x;
  assign world_y  = none_kept ? '0 : cells[0].y;
  assign world_z  = none_kept ? '0 : cells[0].z;
  assign strength = none_kept ? '0 : cells[0].s;
  assign rank     = none_kept ? '0 : RANK_BITS'(emit_idx);

  assign received_count  = seen_count;
  assign too_close_count = near_count;
  assign kept_count      = pass_count;

endmodule
